// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ram's parent and the top level; depends on nothing.
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [15:0] rank;
        logic        [15:0] task_tag;
    } t_in_beat;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [15:0] out_rank;
        logic        [15:0] out_tag;
        logic        [4:0]  count;
    } t_out_beat;

    typedef struct packed {
        logic signed [15:0] rank;
        logic        [15:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue: top level with sequencer and result register.
// Depends on spq_pkg and spq_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one operation
//   per beat: insert a rank and task tag, or remove the lowest-rank entry.
//   Output channel (o_out_valid / i_out_stall / o_out_beat) gives exactly one
//   result beat per operation: status, removed rank and tag (zero unless a
//   remove succeeded), and the count held afterwards. Equal ranks leave in order.
// Sequence
//   Insert walks down from the top entry, moving each larger entry up one
//   place, and stops at the first entry not larger; into an empty queue it
//   writes the head directly. Remove reads the head and moves the others down
//   one place. A refused operation goes straight to the result stage. Every
//   operation then waits in S_DONE to load the result register. The single
//   memory port moves one entry per cycle during the walk or the shift.
//   o_in_stall is high from acceptance until the result is loaded for output.
// Reset: synchronous, active low; the queue empties and the output goes invalid.
//   Memory contents are not cleared; only entries below the count are read.
// Stall: a stalled result holds in the output register; the next operation is
//   still taken and worked, and waits for the register to drain at its end.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INS   = 6'b000010,
        S_PUT   = 6'b000100,
        S_POP   = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic               r_out_valid, n_out_valid;
    t_entry             r_new, n_new;
    t_out_beat          r_res, n_res;
    t_out_beat          r_out, n_out;

    // memory port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_entry             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd;

    logic               in_acc;
    logic               out_take;
    logic [CNT_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   pos_m2;
    logic [CNT_W-1:0]   pos_p1;
    logic [CNT_W-1:0]   fill_m1;
    logic [CNT_W-1:0]   fill_p1;
    logic               rd_greater;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd         = t_entry'(ram_rdata);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign pos_m1     = r_pos - CNT_W'(1);
    assign pos_m2     = r_pos - CNT_W'(2);
    assign pos_p1     = r_pos + CNT_W'(1);
    assign fill_m1    = r_fill - CNT_W'(1);
    assign fill_p1    = r_fill + CNT_W'(1);
    // the one shared comparator: is the entry just read ranked above the new one
    assign rd_greater = $signed(rd.rank) > $signed(r_new.rank);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_new       = r_new;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_pos[ADDR_W-1:0];
        ram_wdata   = r_new;
        ram_raddr   = '0;

        // drop a result once taken; a fresh load below overrides this
        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_new.rank  = i_in_beat.rank;
                    n_new.tag   = i_in_beat.task_tag;
                    n_res       = '0;
                    n_res.count = 5'(r_fill);
                    if (i_in_beat.op == OP_INSERT) begin
                        if (r_fill == CNT_W'(DEPTH)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else if (r_fill == '0) begin
                            // empty queue: write straight into the head
                            ram_we         = 1'b1;
                            ram_waddr      = '0;
                            ram_wdata.rank = i_in_beat.rank;
                            ram_wdata.tag  = i_in_beat.task_tag;
                            n_fill         = fill_p1;
                            n_res.count    = 5'(fill_p1);
                            n_state        = S_DONE;
                        end else begin
                            ram_raddr = fill_m1[ADDR_W-1:0];
                            n_pos     = r_fill;
                            n_state   = S_INS;
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            ram_raddr = '0;
                            n_state   = S_POP;
                        end
                    end
                end
            end
            S_INS: begin
                // entry r_pos-1 is on the read port; r_pos is the free slot
                if (rd_greater) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd;
                    if (r_pos == CNT_W'(1)) begin
                        n_pos   = '0;
                        n_state = S_PUT;
                    end else begin
                        ram_raddr = pos_m2[ADDR_W-1:0];
                        n_pos     = pos_m1;
                    end
                end else begin
                    ram_we      = 1'b1;
                    n_fill      = fill_p1;
                    n_res.count = 5'(fill_p1);
                    n_state     = S_DONE;
                end
            end
            S_PUT: begin
                ram_we      = 1'b1;
                n_fill      = fill_p1;
                n_res.count = 5'(fill_p1);
                n_state     = S_DONE;
            end
            S_POP: begin
                n_res.out_rank = rd.rank;
                n_res.out_tag  = rd.tag;
                if (r_fill == CNT_W'(1)) begin
                    n_fill      = fill_m1;
                    n_res.count = 5'(fill_m1);
                    n_state     = S_DONE;
                end else begin
                    ram_raddr = ADDR_W'(1);
                    n_pos     = CNT_W'(1);
                    n_state   = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // move entry r_pos down one place
                ram_we    = 1'b1;
                ram_waddr = pos_m1[ADDR_W-1:0];
                ram_wdata = rd;
                if (r_pos == fill_m1) begin
                    n_fill      = fill_m1;
                    n_res.count = 5'(fill_m1);
                    n_state     = S_DONE;
                end else begin
                    ram_raddr = pos_p1[ADDR_W-1:0];
                    n_pos     = pos_p1;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // the count never leaves its range
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // the count moves by one at most, per operation
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_fill) |->
            ((CNT_W+1)'(r_fill) == (CNT_W+1)'($past(r_fill)) + (CNT_W+1)'(1)) ||
            ((CNT_W+1)'(r_fill) + (CNT_W+1)'(1) == (CNT_W+1)'($past(r_fill))))
        else $error("fill count jumped");

    // the insert walk stays inside the held entries
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_pos != '0) && (r_pos <= r_fill))
        else $error("insert walk out of range");

    // a refusal reports the count that caused it
    a_refuse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_beat.status != ST_FULL) || (o_out_beat.count == 5'(DEPTH))) &&
            ((o_out_beat.status != ST_EMPTY) || (o_out_beat.count == 5'd0)))
        else $error("refusal with wrong count");

endmodule
